>>> rtl/core/fpa_pkg.sv
// Shared types and constants for the fixed partition allocator.
package fpa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_WRSIZE  = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NO_OWNER = 2'd2,
    ST_BAD_IDX  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_DONE = 2'd2
  } fsm_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_size;
    logic [1:0]  policy;
    logic [15:0] owner_id;
    logic [3:0]  slot_index;
    logic [15:0] new_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_slot;
    logic [15:0] granted_id;
  } rsp_t;

  // Running candidate kept by the controller while the ring shifts during a scan.
  typedef struct packed {
    logic        found;
    logic [3:0]  slot;
    logic [15:0] size;
  } cand_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic        commit_alloc;
    logic        commit_free;
    logic        commit_size;
    logic [3:0]  slot;
    logic [15:0] owner;
    logic [15:0] size;
  } cell_cmd_t;

  function automatic logic [15:0] init_size(input int unsigned idx);
    case (idx)
      0: init_size = 16'd100;
      1: init_size = 16'd500;
      2: init_size = 16'd200;
      3: init_size = 16'd300;
      4: init_size = 16'd600;
      5: init_size = 16'd150;
      6: init_size = 16'd400;
      7: init_size = 16'd250;
      8: init_size = 16'd350;
      9: init_size = 16'd120;
      default: init_size = 16'd0;
    endcase
  endfunction

endpackage

>>> rtl/core/fixed_partition_allocator.sv
// Fixed partition allocator: ring of partition cells plus a scan controller.
// A request is scanned with one ring shift per partition through the head cell;
//   the result is then held in the DONE state until taken.
// One item in flight at a time: a new request is taken only when idle.
// Reset (rst_ni low, async): sizes to the boot table, all partitions free,
//   owners 0, rover 0, id counter 1. No clearing pass.
module fixed_partition_allocator #(
  parameter int unsigned NUM_SLOTS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fpa_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fpa_pkg::rsp_t  out_data_o
);

  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);

  fpa_pkg::fsm_e state_q, state_d;
  fpa_pkg::req_t req_q;
  fpa_pkg::cand_t cand_q, cand_d;
  fpa_pkg::cell_cmd_t cmd;
  fpa_pkg::rsp_t rsp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [3:0]  rover_q, rover_d;
  logic [15:0] id_q, id_d;
  logic        load, shift;

  // Ring wiring: cell k takes from cell k+1; the last wraps to cell 0.
  logic [3:0]  r_slot  [NUM_SLOTS];
  logic [15:0] r_size  [NUM_SLOTS];
  logic        r_busy  [NUM_SLOTS];
  logic [15:0] r_owner [NUM_SLOTS];

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    localparam int unsigned Nx = (k + 1) % NUM_SLOTS;
    fpa_cell #(.Idx(k)) u_cell (
      .clk_i, .rst_ni,
      .load_i      (load),
      .shift_i     (shift),
      .cmd_i       (cmd),
      .ring_slot_i (r_slot[Nx]),
      .ring_size_i (r_size[Nx]),
      .ring_busy_i (r_busy[Nx]),
      .ring_owner_i(r_owner[Nx]),
      .ring_slot_o (r_slot[k]),
      .ring_size_o (r_size[k]),
      .ring_busy_o (r_busy[k]),
      .ring_owner_o(r_owner[k])
    );
  end

  // Head cell view, i.e. the partition examined this cycle.
  logic [3:0]  h_slot;
  logic [15:0] h_size;
  logic        h_fit, h_own, take;
  assign h_slot = r_slot[0];
  assign h_size = r_size[0];
  assign h_fit  = !r_busy[0] && (h_size >= req_q.request_size);
  assign h_own  = r_busy[0] && (r_owner[0] == req_q.owner_id);

  // Next fit examines in rotated order: rank = (slot - rover) mod N via compare.
  always_comb begin
    take = 1'b0;
    case (fpa_pkg::opcode_e'(req_q.opcode))
      fpa_pkg::OP_RELEASE: take = h_own && !cand_q.found;
      fpa_pkg::OP_ALLOC: begin
        case (fpa_pkg::policy_e'(req_q.policy))
          fpa_pkg::POL_FIRST: take = h_fit && !cand_q.found;
          fpa_pkg::POL_BEST:  take = h_fit && (!cand_q.found || h_size < cand_q.size);
          fpa_pkg::POL_WORST: take = h_fit && (!cand_q.found || h_size > cand_q.size);
          fpa_pkg::POL_NEXT: begin
            // prefer slots at/after rover; among same class lowest index wins
            if (h_fit) begin
              if (!cand_q.found) take = 1'b1;
              else if (cand_q.slot < rover_q && h_slot >= rover_q) take = 1'b1;
            end
          end
          default: take = 1'b0;
        endcase
      end
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fpa_pkg::FSM_IDLE: if (in_valid_i) state_d = fpa_pkg::FSM_SCAN;
      fpa_pkg::FSM_SCAN: if (cnt_q == CntW'(NUM_SLOTS - 1)) state_d = fpa_pkg::FSM_DONE;
      fpa_pkg::FSM_DONE: if (out_ready_i) state_d = fpa_pkg::FSM_IDLE;
      default: state_d = fpa_pkg::FSM_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    load   = (state_q == fpa_pkg::FSM_IDLE) && in_valid_i;
    shift  = (state_q == fpa_pkg::FSM_SCAN);
    cnt_d  = load ? '0 : (shift ? cnt_q + 1'b1 : cnt_q);
    cand_d = cand_q;
    if (load) cand_d = '0;
    else if (shift && take) cand_d = '{found: 1'b1, slot: h_slot, size: h_size};
    rover_d = rover_q;
    id_d    = id_q;
    cmd     = '0;
    rsp_d   = '{status: fpa_pkg::ST_BAD_IDX, chosen_slot: 4'd0, granted_id: 16'd0};
    case (fpa_pkg::opcode_e'(req_q.opcode))
      fpa_pkg::OP_ALLOC: begin
        if (cand_q.found) begin
          rsp_d = '{status: fpa_pkg::ST_OK, chosen_slot: cand_q.slot, granted_id: id_q};
          cmd.commit_alloc = 1'b1;
          cmd.slot  = cand_q.slot;
          cmd.owner = id_q;
        end else rsp_d.status = fpa_pkg::ST_NO_FIT;
      end
      fpa_pkg::OP_RELEASE: begin
        if (cand_q.found) begin
          rsp_d.status = fpa_pkg::ST_OK;
          rsp_d.chosen_slot = cand_q.slot;
          cmd.commit_free = 1'b1;
          cmd.slot = cand_q.slot;
        end else rsp_d.status = fpa_pkg::ST_NO_OWNER;
      end
      fpa_pkg::OP_WRSIZE: begin
        if (32'(req_q.slot_index) < NUM_SLOTS) begin
          rsp_d.status = fpa_pkg::ST_OK;
          rsp_d.chosen_slot = req_q.slot_index;
          cmd.commit_size = 1'b1;
          cmd.slot = req_q.slot_index;
          cmd.size = req_q.new_size;
        end
      end
      default: ;
    endcase
    // Commit only on the result beat.
    if (!(state_q == fpa_pkg::FSM_DONE && out_ready_i)) begin
      cmd.commit_alloc = 1'b0;
      cmd.commit_free  = 1'b0;
      cmd.commit_size  = 1'b0;
    end
    if (cmd.commit_alloc) begin
      id_d = (id_q == 16'hFFFF) ? 16'd1 : id_q + 16'd1;
      if (fpa_pkg::policy_e'(req_q.policy) == fpa_pkg::POL_NEXT)
        rover_d = (32'(cand_q.slot) + 1 < NUM_SLOTS) ? cand_q.slot + 4'd1 : 4'd0;
    end
  end

  assign in_ready_o  = (state_q == fpa_pkg::FSM_IDLE);
  assign out_valid_o = (state_q == fpa_pkg::FSM_DONE);
  assign out_data_o  = rsp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpa_pkg::FSM_IDLE;
      cnt_q   <= '0;
      cand_q  <= '0;
      rover_q <= '0;
      id_q    <= 16'd1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cand_q  <= cand_d;
      rover_q <= rover_d;
      id_q    <= id_d;
    end
  end

  // Hold the request beat for the scan.
  always_ff @(posedge clk_i) begin
    if (load) req_q <= in_data_i;
  end

endmodule

>>> rtl/core/fpa_cell.sv
// One partition cell: holds its entry and shifts its view of it along a ring.
module fpa_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                shift_i,
  input  fpa_pkg::cell_cmd_t  cmd_i,
  input  logic [3:0]          ring_slot_i,
  input  logic [15:0]         ring_size_i,
  input  logic                ring_busy_i,
  input  logic [15:0]         ring_owner_i,
  output logic [3:0]          ring_slot_o,
  output logic [15:0]         ring_size_o,
  output logic                ring_busy_o,
  output logic [15:0]         ring_owner_o
);

  logic [15:0] size_q;
  logic        busy_q;
  logic [15:0] owner_q;
  logic        hit;

  assign hit = (cmd_i.slot == 4'(Idx));

  // Home entry: update on commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= fpa_pkg::init_size(Idx);
      busy_q  <= 1'b0;
      owner_q <= '0;
    end else if (hit) begin
      if (cmd_i.commit_alloc) begin
        busy_q  <= 1'b1;
        owner_q <= cmd_i.owner;
      end
      if (cmd_i.commit_free) begin
        busy_q  <= 1'b0;
        owner_q <= '0;
      end
      if (cmd_i.commit_size) size_q <= cmd_i.size;
    end
  end

  // Ring copy: load from home, then hand to the neighbor each cycle while shifting.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ring_slot_o  <= 4'(Idx);
      ring_size_o  <= size_q;
      ring_busy_o  <= busy_q;
      ring_owner_o <= owner_q;
    end else if (shift_i) begin
      ring_slot_o  <= ring_slot_i;
      ring_size_o  <= ring_size_i;
      ring_busy_o  <= ring_busy_i;
      ring_owner_o <= ring_owner_i;
    end
  end

endmodule

>>> rtl/core/fpa_checker.sv
// Port-level checker for the fixed partition allocator, bound to the top level.
module fpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input fpa_pkg::rsp_t out_data_o
);

  // One item in flight: never ready while a result waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");

  // Accepted beat leaves no immediate result.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result too early");

  // Error statuses carry no slot or id.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != fpa_pkg::ST_OK) |->
      (out_data_o.chosen_slot == 4'd0 && out_data_o.granted_id == 16'd0))
    else $error("error result with payload");

  // Held result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped or changed");

endmodule

bind fixed_partition_allocator fpa_checker u_fpa_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
